// ===== hdl/biq_pkg.sv =====
// shared types, constants and register codes for the biquad filter
package biq_pkg;

    localparam int CHANNELS = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int ACC_W    = 32;
    localparam int Q_SHIFT  = 15;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [COEFF_W-1:0] B0_RESET = 16'sd2399;
    localparam logic signed [COEFF_W-1:0] B1_RESET = 16'sd4799;
    localparam logic signed [COEFF_W-1:0] B2_RESET = 16'sd2399;
    localparam logic signed [COEFF_W-1:0] A1_RESET = 16'sd1;
    localparam logic signed [COEFF_W-1:0] A2_RESET = -16'sd2811;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } biq_reg_idx_t;

    typedef struct packed {
        logic [0:0]                  channel;
        logic signed [SAMPLE_W-1:0]  sample_in;
    } biq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic [0:0]                  channel_out;
    } biq_out_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] b0;
        logic signed [COEFF_W-1:0] b1;
        logic signed [COEFF_W-1:0] b2;
        logic signed [COEFF_W-1:0] a1;
        logic signed [COEFF_W-1:0] a2;
    } biq_coeff_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } biq_taps_t;

endpackage

// ===== hdl/biq_cfg.sv =====
// apb coefficient register file for the biquad filter
module biq_cfg
    import biq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output biq_coeff_t        coeff
);

    biq_coeff_t   coeff_reg;
    biq_reg_idx_t idx;
    logic         wr_en;

    assign idx    = biq_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coeff  = coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg.b0 <= B0_RESET;
            coeff_reg.b1 <= B1_RESET;
            coeff_reg.b2 <= B2_RESET;
            coeff_reg.a1 <= A1_RESET;
            coeff_reg.a2 <= A2_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_B0:  coeff_reg.b0 <= pwdata[COEFF_W-1:0];
                REG_B1:  coeff_reg.b1 <= pwdata[COEFF_W-1:0];
                REG_B2:  coeff_reg.b2 <= pwdata[COEFF_W-1:0];
                REG_A1:  coeff_reg.a1 <= pwdata[COEFF_W-1:0];
                REG_A2:  coeff_reg.a2 <= pwdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_B0:  prdata[COEFF_W-1:0] = coeff_reg.b0;
            REG_B1:  prdata[COEFF_W-1:0] = coeff_reg.b1;
            REG_B2:  prdata[COEFF_W-1:0] = coeff_reg.b2;
            REG_A1:  prdata[COEFF_W-1:0] = coeff_reg.a1;
            REG_A2:  prdata[COEFF_W-1:0] = coeff_reg.a2;
            default: prdata = '0;
        endcase
    end

endmodule

// ===== hdl/biq_mac.sv =====
// five-tap multiply-accumulate with clamp and q15 rescale
module biq_mac
    import biq_pkg::*;
(
    input  biq_coeff_t                 coeff,
    input  biq_taps_t                  taps,
    output logic signed [SAMPLE_W-1:0] y
);

    logic signed [ACC_W-1:0] p_b0;
    logic signed [ACC_W-1:0] p_b1;
    logic signed [ACC_W-1:0] p_b2;
    logic signed [ACC_W-1:0] p_a1;
    logic signed [ACC_W-1:0] p_a2;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sat;

    assign p_b0 = coeff.b0 * taps.x;
    assign p_b1 = coeff.b1 * taps.x1;
    assign p_b2 = coeff.b2 * taps.x2;
    assign p_a1 = coeff.a1 * taps.y1;
    assign p_a2 = coeff.a2 * taps.y2;

    // wraps modulo 2^32
    assign acc = p_b0 + p_b1 + p_b2 + p_a1 + p_a2;

    // clamp to [-2^30, 2^30-1] from the top two bits
    always_comb
    begin
        acc_sat = acc;
        if (acc[ACC_W-1] != acc[ACC_W-2])
        begin
            acc_sat = {acc[ACC_W-1], acc[ACC_W-1], {(ACC_W-2){~acc[ACC_W-1]}}};
        end
    end

    assign y = acc_sat[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];

endmodule

// ===== hdl/biquad_iir_filter_q15.sv =====
// top level of the two-channel q15 direct form 1 biquad filter
//
// sample channel: sample_valid / sample_stall / sample_beat carry a channel
// tag and a signed 16-bit sample; a beat is taken when valid is high and
// stall is low. result channel: result_valid / result_stall / result_beat
// carry the filtered sample and the copied tag, exactly one per sample.
// coefficients b0, b1, b2, a1, a2 sit on the apb port at byte addresses
// 0, 4, 8, 12, 16; write them only while no sample is in flight.
// each sample passes the input register, then the multiply-accumulate
// into the result register. throughput: one sample per cycle while the
// receiver does not stall, either channel in any order; the per-channel
// history is updated as each sample reaches the result register, so a
// following sample of the same channel sees it.
// reset clears the history of both channels to zero, empties both
// stages and loads the default coefficients.
// when the receiver stalls, the result register holds; one more sample is
// taken into the input register, then sample_stall rises.
module biquad_iir_filter_q15
    import biq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  biq_in_t           sample_beat,
    output logic              result_valid,
    input  logic              result_stall,
    output biq_out_t          result_beat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    biq_coeff_t coeff;
    biq_taps_t  taps;

    logic        in_valid_reg;
    logic        in_valid_next;
    biq_in_t     in_beat_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    biq_out_t    out_beat_reg;

    logic signed [SAMPLE_W-1:0] x1_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] x2_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y1_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y2_reg [CHANNELS];

    logic                       accept;
    logic                       advance;
    logic [0:0]                 bank;
    logic signed [SAMPLE_W-1:0] y;

    biq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    assign bank    = in_beat_reg.channel;
    assign taps.x  = in_beat_reg.sample_in;
    assign taps.x1 = x1_reg[bank];
    assign taps.x2 = x2_reg[bank];
    assign taps.y1 = y1_reg[bank];
    assign taps.y2 = y2_reg[bank];

    biq_mac u_mac (
        .coeff (coeff),
        .taps  (taps),
        .y     (y)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && out_valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg <= sample_beat;
        end
        if (advance)
        begin
            out_beat_reg.sample_out  <= y;
            out_beat_reg.channel_out <= in_beat_reg.channel;
        end
    end

    // per-channel delay lines shift as the result is registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            x2_reg[bank] <= x1_reg[bank];
            x1_reg[bank] <= in_beat_reg.sample_in;
            y2_reg[bank] <= y1_reg[bank];
            y1_reg[bank] <= y;
        end
    end

endmodule
